>>> hdl/lzwd_pkg.sv
`default_nettype none

package lzwd_pkg;

    localparam int WINDOW_SIZE      = 4096;
    localparam int ADDR_W           = $clog2(WINDOW_SIZE);
    localparam int BYTES_PER_RESULT = 8;
    localparam int CNT_W            = 4;
    localparam int LEN_W            = 9;
    localparam int SIZE_W           = 32;
    localparam int CMD_DEPTH        = 4;

    localparam logic [3:0] FLAGS_PER_CODE = 4'd8;
    localparam logic [8:0] SHORT_LEN_BIAS = 9'd2;
    localparam logic [8:0] LONG_LEN_BIAS  = 9'h12;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } item_t;

    typedef struct packed {
        logic [8*BYTES_PER_RESULT-1:0] out_bytes;
        logic [CNT_W-1:0]              out_count;
        logic                          run_last;
        logic                          stream_done;
    } result_t;

    // one decoded operation handed from the parser to the copy engine
    typedef struct packed {
        logic              is_lit;
        logic [7:0]        lit;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] offset;
        logic              restart;
        logic              done;
    } cmd_t;

endpackage

`default_nettype wire

>>> hdl/lzwd_ram.sv
`default_nettype none

module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/lzwd_cmd_fifo.sv
`default_nettype none

module lzwd_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire lzwd_pkg::cmd_t wr_cmd,
    output logic               full,
    input  wire logic          rd_en,
    output lzwd_pkg::cmd_t     rd_cmd,
    output logic               empty
);
    import lzwd_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_FW = $clog2(CMD_DEPTH + 1);

    cmd_t              slot_reg [CMD_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_FW-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign full   = (count_reg == CNT_FW'(CMD_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = slot_reg[rptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;

    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lzwd_front.sv
`default_nettype none

module lzwd_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire lzwd_pkg::item_t         item,
    input  wire logic [lzwd_pkg::SIZE_W-1:0] size,
    output logic                         cmd_push,
    output lzwd_pkg::cmd_t               cmd
);
    import lzwd_pkg::*;

    localparam logic [1:0] PH_CODE = 2'd0;
    localparam logic [1:0] PH_ITEM = 2'd1;
    localparam logic [1:0] PH_REF2 = 2'd2;
    localparam logic [1:0] PH_REF3 = 2'd3;

    logic [7:0]        flags_reg, flags_next;
    logic [3:0]        left_reg, left_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        second_reg, second_next;
    logic [SIZE_W-1:0] produced_reg, produced_next;
    logic              pend_reg, pend_next;

    logic [7:0]        flags_e, first_e, second_e;
    logic [3:0]        left_e;
    logic [1:0]        phase_e;
    logic [SIZE_W-1:0] produced_e;
    logic [SIZE_W-1:0] remain;
    logic              issue, is_lit, step_flag, clip;
    logic [LEN_W-1:0]  len, len_clip;
    logic [ADDR_W-1:0] offset;
    logic [7:0]        b;

    assign b = item.in_byte;

    always_comb
    begin
        // stream start clears the parser before the byte is looked at
        flags_e    = item.stream_start ? '0 : flags_reg;
        left_e     = item.stream_start ? '0 : left_reg;
        phase_e    = item.stream_start ? PH_CODE : phase_reg;
        first_e    = item.stream_start ? '0 : first_reg;
        second_e   = item.stream_start ? '0 : second_reg;
        produced_e = item.stream_start ? '0 : produced_reg;

        flags_next    = flags_reg;
        left_next     = left_reg;
        phase_next    = phase_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        produced_next = produced_reg;
        pend_next     = pend_reg;

        issue     = 1'b0;
        is_lit    = 1'b0;
        step_flag = 1'b0;
        len       = '0;
        offset    = '0;

        remain   = size - produced_e;
        len_clip = '0;
        clip     = 1'b0;

        if (accept)
        begin
            flags_next    = flags_e;
            left_next     = left_e;
            phase_next    = phase_e;
            first_next    = first_e;
            second_next   = second_e;
            produced_next = produced_e;
            if (item.stream_start)
            begin
                pend_next = 1'b1;
            end

            if (produced_e < size)
            begin
                unique case (phase_e)
                    PH_CODE:
                    begin
                        flags_next = b;
                        left_next  = FLAGS_PER_CODE;
                        phase_next = PH_ITEM;
                    end
                    PH_ITEM:
                    begin
                        if (flags_e[7])
                        begin
                            issue     = 1'b1;
                            is_lit    = 1'b1;
                            len       = LEN_W'(1);
                            step_flag = 1'b1;
                        end
                        else
                        begin
                            first_next = b;
                            phase_next = PH_REF2;
                        end
                    end
                    PH_REF2:
                    begin
                        second_next = b;
                        if (first_e[7:4] != 4'd0)
                        begin
                            issue     = 1'b1;
                            len       = {5'd0, first_e[7:4]} + SHORT_LEN_BIAS;
                            offset    = {first_e[3:0], b};
                            step_flag = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_REF3;
                        end
                    end
                    PH_REF3:
                    begin
                        issue     = 1'b1;
                        len       = {1'b0, b} + LONG_LEN_BIAS;
                        offset    = {first_e[3:0], second_e};
                        step_flag = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_CODE;
                    end
                endcase

                if (step_flag)
                begin
                    flags_next = {flags_e[6:0], 1'b0};
                    left_next  = left_e - 1'b1;
                    phase_next = (left_e == 4'd1) ? PH_CODE : PH_ITEM;
                end

                // clip the run at the configured size
                clip     = ({{(SIZE_W-LEN_W){1'b0}}, len} >= remain);
                len_clip = clip ? remain[LEN_W-1:0] : len;
                if (issue)
                begin
                    produced_next = produced_e + {{(SIZE_W-LEN_W){1'b0}}, len_clip};
                    pend_next     = 1'b0;
                end
            end
        end

        cmd_push    = issue;
        cmd.is_lit  = is_lit;
        cmd.lit     = b;
        cmd.len     = len_clip;
        cmd.offset  = offset;
        cmd.restart = pend_reg || item.stream_start;
        cmd.done    = clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            left_reg     <= '0;
            phase_reg    <= PH_CODE;
            first_reg    <= '0;
            second_reg   <= '0;
            produced_reg <= '0;
            pend_reg     <= 1'b1;
        end
        else
        begin
            flags_reg    <= flags_next;
            left_reg     <= left_next;
            phase_reg    <= phase_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            produced_reg <= produced_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lzwd_back.sv
`default_nettype none

module lzwd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_empty,
    input  wire lzwd_pkg::cmd_t   cmd,
    output logic                  cmd_pop,
    output logic                  res_valid,
    output lzwd_pkg::result_t     res,
    input  wire logic             res_pop
);
    import lzwd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    localparam int ACC_W = 8 * BYTES_PER_RESULT;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] wi_reg, wi_next;
    logic              wrapped_reg, wrapped_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic              src_ok_reg, src_ok_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic              is_lit_reg, is_lit_next;
    logic [7:0]        lit_reg, lit_next;
    logic              done_reg, done_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic [ADDR_W-1:0] wi_base;
    logic [7:0]        rd_data, byte_val;
    logic              ram_we, ram_re;
    logic              last_byte, emit, slot_free;
    logic [ACC_W-1:0]  acc_new;

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg),
        .wdata (byte_val),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (rd_data)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        wi_next        = wi_reg;
        wrapped_next   = wrapped_reg;
        src_next       = src_reg;
        src_ok_next    = src_ok_reg;
        left_next      = left_reg;
        is_lit_next    = is_lit_reg;
        lit_next       = lit_reg;
        done_next      = done_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg && !res_pop;
        res_next       = res_reg;

        slot_free = !res_valid_reg || res_pop;
        cmd_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        wi_base   = cmd.restart ? '0 : wi_reg;

        // entries not yet written in this stream read as zero
        byte_val  = is_lit_reg ? lit_reg : (src_ok_reg ? rd_data : 8'd0);
        last_byte = (left_reg == LEN_W'(1));
        emit      = last_byte || (cnt_reg == CNT_W'(BYTES_PER_RESULT - 1));
        acc_new   = acc_reg | ({{(ACC_W-8){1'b0}}, byte_val} << {cnt_reg[2:0], 3'b000});

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop     = 1'b1;
                    wi_next     = wi_base;
                    if (cmd.restart)
                    begin
                        wrapped_next = 1'b0;
                    end
                    src_next    = wi_base - cmd.offset - 1'b1;
                    left_next   = cmd.len;
                    is_lit_next = cmd.is_lit;
                    lit_next    = cmd.lit;
                    done_next   = cmd.done;
                    state_next  = cmd.is_lit ? ST_WRITE : ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re      = 1'b1;
                src_ok_next = wrapped_reg || (src_reg < wi_reg);
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold the byte while a finished result has nowhere to go
                if (!emit || slot_free)
                begin
                    ram_we    = 1'b1;
                    wi_next   = wi_reg + 1'b1;
                    if (wi_reg == ADDR_W'(WINDOW_SIZE - 1))
                    begin
                        wrapped_next = 1'b1;
                    end
                    src_next  = src_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                    if (emit)
                    begin
                        res_valid_next       = 1'b1;
                        res_next.out_bytes   = acc_new;
                        res_next.out_count   = cnt_reg + 1'b1;
                        res_next.run_last    = last_byte;
                        res_next.stream_done = last_byte && done_reg;
                        acc_next             = '0;
                        cnt_next             = '0;
                    end
                    else
                    begin
                        acc_next = acc_new;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = last_byte ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wi_reg        <= '0;
            wrapped_reg   <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wi_reg        <= wi_next;
            wrapped_reg   <= wrapped_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        src_ok_reg <= src_ok_next;
        left_reg   <= left_next;
        is_lit_reg <= is_lit_next;
        lit_reg    <= lit_next;
        done_reg   <= done_next;
        res_reg    <= res_next;
    end

endmodule

`default_nettype wire

>>> hdl/lz_window_decompressor.sv
`default_nettype none

// Yaz0 body decompressor. Compressed bytes are pushed one per cycle into a
// parser that decodes code bytes, literals and back-references and clips each
// run at uncompressed_size; it can take one byte every cycle until its
// four-entry command queue is full. The copy engine behind the queue drains
// commands through a 4096-byte history RAM, with one read and one write
// of the history per byte of a back-reference. Results carry up to eight
// bytes, first byte in the low lane. The history needs no clearing pass:
// bytes not yet written since the last stream start read as zero. Write
// uncompressed_size only while idle.
module lz_window_decompressor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire lzwd_pkg::item_t             item,
    output logic                             empty,
    input  wire logic                        pop,
    output lzwd_pkg::result_t                result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lzwd_pkg::SIZE_W-1:0] cfg_data
);
    import lzwd_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic              accept;
    logic              cmd_push, cmd_pop, cmd_empty, cmd_full;
    cmd_t              cmd_in, cmd_out;
    logic              res_valid;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign accept    = push && !cmd_full;
    assign empty     = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_valid)
        begin
            size_reg <= cfg_data;
        end
    end

    lzwd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .size     (size_reg),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    lzwd_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd_in),
        .full   (cmd_full),
        .rd_en  (cmd_pop),
        .rd_cmd (cmd_out),
        .empty  (cmd_empty)
    );

    lzwd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (result),
        .res_pop   (pop)
    );

endmodule

`default_nettype wire
